/* sv/scfh_pkg.sv */
package scfh_pkg;

	localparam int COORD_W            = 32;
	localparam int TOL_W              = 16;
	localparam int COORD_FRAC_DEFAULT = 16;
	localparam int TIME_FRAC_DEFAULT  = 16;
	localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

endpackage

/* sv/segment_circle_first_hit.sv */
// Segment against circle, first contact. One segment/circle pair is taken per clock
// while the result side does not stall, and each produces one result; the default
// formats are Q16.16 for coordinates and Q1.16 for hit_time. The depth is set by the
// exact square root of the scaled discriminant, which resolves one root bit per
// stage, followed by a restoring divider that yields one hit_time bit per stage.
// All tolerance tests are exact, so hit and hit_time never depend on rounding. A stall
// on the result side holds the whole pipeline in place; in_stall rises only while a
// result waits and is stalled.
// The tolerance register must be written only while no transfer is in flight.
module segment_circle_first_hit import scfh_pkg::*; #(
	parameter int COORD_FRAC_BITS = COORD_FRAC_DEFAULT,
	parameter int TIME_FRAC_BITS  = TIME_FRAC_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [TOL_W-1:0]            cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [COORD_W-1:0]   start_x,
	input  logic signed [COORD_W-1:0]   start_y,
	input  logic signed [COORD_W-1:0]   end_x,
	input  logic signed [COORD_W-1:0]   end_y,
	input  logic signed [COORD_W-1:0]   center_x,
	input  logic signed [COORD_W-1:0]   center_y,
	input  logic signed [COORD_W-1:0]   sum_radius,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        hit,
	output logic [TIME_FRAC_BITS:0]     hit_time
);

	localparam int W  = (COORD_FRAC_BITS > TIME_FRAC_BITS) ? COORD_FRAC_BITS : TIME_FRAC_BITS;
	localparam int NB = 65 + W;      // root bits
	localparam int RW = 2 * NB;      // radicand / remainder width
	localparam int AW = 67 + W;      // -P scaled
	localparam int YW = 76 + W;      // root numerators and bounds
	localparam int DW = 66 + W;      // divider remainder
	localparam int TW = TIME_FRAC_BITS + 1;
	localparam int T  = TIME_FRAC_BITS;

	logic             adv;
	logic [TOL_W-1:0] tol_q;

	assign in_stall = out_valid && out_stall;
	assign adv      = !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	// ---------------- s1: differences, radius ----------------
	logic signed [32:0] dx_s1, dy_s1, ox_s1, oy_s1;
	logic [31:0]        rad_s1;
	logic               v_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1  <= {end_x[31], end_x} - {start_x[31], start_x};
			dy_s1  <= {end_y[31], end_y} - {start_y[31], start_y};
			ox_s1  <= {start_x[31], start_x} - {center_x[31], center_x};
			oy_s1  <= {start_y[31], start_y} - {center_y[31], center_y};
			rad_s1 <= (sum_radius[31] ? 32'd0 : {1'b0, sum_radius[30:0]}) + {16'd0, tol_q};
		end
	end

	// ---------------- s2: products ----------------
	logic [63:0]        pdxdx_s2, pdydy_s2, poxox_s2, poyoy_s2, r2_s2;
	logic signed [65:0] poxdx_s2, poydy_s2, poxdy_s2, poydx_s2;
	logic               v_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			pdxdx_s2 <= dx_s1 * dx_s1;
			pdydy_s2 <= dy_s1 * dy_s1;
			poxox_s2 <= ox_s1 * ox_s1;
			poyoy_s2 <= oy_s1 * oy_s1;
			poxdx_s2 <= ox_s1 * dx_s1;
			poydy_s2 <= oy_s1 * dy_s1;
			poxdy_s2 <= ox_s1 * dy_s1;
			poydx_s2 <= oy_s1 * dx_s1;
			r2_s2    <= rad_s1 * rad_s1;
		end
	end

	// ---------------- s3: L, P, |O|^2, cross ----------------
	logic [64:0]        len_s3, oo_s3;
	logic signed [66:0] dot_s3, cr_s3;
	logic [63:0]        r2_s3;
	logic               v_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			len_s3 <= {1'b0, pdxdx_s2} + {1'b0, pdydy_s2};
			oo_s3  <= {1'b0, poxox_s2} + {1'b0, poyoy_s2};
			dot_s3 <= {poxdx_s2[65], poxdx_s2} + {poydy_s2[65], poydy_s2};
			cr_s3  <= {poxdy_s2[65], poxdy_s2} - {poydx_s2[65], poydx_s2};
			r2_s3  <= r2_s2;
		end
	end

	// ---------------- s4: partial products, early flags ----------------
	logic [65:0]        pll_s4;
	logic [63:0]        plh_s4;
	logic [64:0]        phl_s4;
	logic [62:0]        phh_s4;
	logic [65:0]        pcll_s4;
	logic signed [67:0] pchl_s4, pchh_s4;
	logic [80:0]        el_s4;
	logic [64:0]        len_s4;
	logic signed [66:0] dot_s4;
	logic               early_s4, inside_s4, v_s4;
	logic signed [33:0] cr_hi, cr_lo;

	assign cr_hi = cr_s3[66:33];
	assign cr_lo = $signed({1'b0, cr_s3[32:0]});

	always_ff @(posedge clk) begin
		if (adv) begin
			pll_s4    <= len_s3[32:0] * r2_s3[32:0];
			plh_s4    <= len_s3[32:0] * r2_s3[63:33];
			phl_s4    <= len_s3[64:33] * r2_s3[32:0];
			phh_s4    <= len_s3[64:33] * r2_s3[63:33];
			pcll_s4   <= cr_s3[32:0] * cr_s3[32:0];
			pchl_s4   <= cr_hi * cr_lo;
			pchh_s4   <= cr_hi * cr_hi;
			el_s4     <= tol_q * len_s3;
			len_s4    <= len_s3;
			dot_s4    <= dot_s3;
			inside_s4 <= oo_s3 <= {1'b0, r2_s3};
			// degenerate segment or start inside: decided without roots
			early_s4  <= (len_s3 <= (65'(tol_q) << COORD_FRAC_BITS)) || (oo_s3 <= {1'b0, r2_s3});
		end
	end

	// ---------------- s5: L*r^2 and cross^2 ----------------
	logic [128:0]        lr2_s5;
	logic [129:0]        cr2_s5;
	logic [80:0]         el_s5;
	logic [64:0]         len_s5;
	logic signed [66:0]  dot_s5;
	logic                early_s5, inside_s5, v_s5;
	logic signed [131:0] cr2_full;

	assign cr2_full = $signed({66'd0, pcll_s4}) + (132'(pchl_s4) <<< 34) + (132'(pchh_s4) <<< 66);

	always_ff @(posedge clk) begin
		if (adv) begin
			lr2_s5    <= 129'(pll_s4) + ((129'(plh_s4) + 129'(phl_s4)) << 33)
				+ (129'(phh_s4) << 66);
			cr2_s5    <= cr2_full[129:0];
			el_s5     <= el_s4;
			len_s5    <= len_s4;
			dot_s5    <= dot_s4;
			early_s5  <= early_s4;
			inside_s5 <= inside_s4;
		end
	end

	// ---------------- s6: discriminant Q ----------------
	logic signed [130:0] q_s6;
	logic [80:0]         el_s6;
	logic [64:0]         len_s6;
	logic signed [66:0]  dot_s6;
	logic                early_s6, inside_s6, v_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s6      <= $signed({2'b00, lr2_s5}) - $signed({1'b0, cr2_s5});
			el_s6     <= el_s5;
			len_s6    <= len_s5;
			dot_s6    <= dot_s5;
			early_s6  <= early_s5;
			inside_s6 <= inside_s5;
		end
	end

	// ---------------- s7 and square root stages ----------------
	logic [RW-1:0]          sqrt_rem_s    [0:NB];
	logic [NB-1:0]          sqrt_root_s   [0:NB];
	logic signed [AW-1:0]   sqrt_a_s      [0:NB];
	logic [64:0]            sqrt_len_s    [0:NB];
	logic [80:0]            sqrt_el_s     [0:NB];
	logic                   sqrt_early_s  [0:NB];
	logic                   sqrt_inside_s [0:NB];
	logic                   sqrt_go_s     [0:NB];
	logic [NB:0]            sqrt_v_s;
	logic signed [133:0]    disc_chk;

	// 4Q + eps*s^3 >= 0
	assign disc_chk = 134'($signed({q_s6, 2'b00}))
		+ $signed(134'(tol_q) << (3 * COORD_FRAC_BITS));

	always_ff @(posedge clk) begin
		if (adv) begin
			sqrt_rem_s[0]    <= q_s6[130] ? '0 : (RW'(q_s6[128:0]) << (2 * W));
			sqrt_root_s[0]   <= '0;
			sqrt_a_s[0]      <= -(AW'(dot_s6) <<< W);
			sqrt_len_s[0]    <= len_s6;
			sqrt_el_s[0]     <= el_s6;
			sqrt_early_s[0]  <= early_s6;
			sqrt_inside_s[0] <= inside_s6;
			sqrt_go_s[0]     <= !early_s6 && !disc_chk[133];
		end
	end

	for (genvar k = 0; k < NB; k++) begin : g_sqrt
		localparam int B = NB - 1 - k;
		logic [RW-1:0] trial;
		logic          take;

		assign trial = (RW'(sqrt_root_s[k]) << (B + 1)) | (RW'(1) << (2 * B));
		assign take  = sqrt_rem_s[k] >= trial;

		always_ff @(posedge clk) begin
			if (adv) begin
				sqrt_rem_s[k+1]    <= take ? sqrt_rem_s[k] - trial : sqrt_rem_s[k];
				sqrt_root_s[k+1]   <= take ? (sqrt_root_s[k] | (NB'(1) << B)) : sqrt_root_s[k];
				sqrt_a_s[k+1]      <= sqrt_a_s[k];
				sqrt_len_s[k+1]    <= sqrt_len_s[k];
				sqrt_el_s[k+1]     <= sqrt_el_s[k];
				sqrt_early_s[k+1]  <= sqrt_early_s[k];
				sqrt_inside_s[k+1] <= sqrt_inside_s[k];
				sqrt_go_s[k+1]     <= sqrt_go_s[k];
			end
		end
	end

	// ---------------- s8: root numerators and bounds ----------------
	// floor/ceil of the exact root give exact tests for the real roots
	logic signed [YW-1:0] ym_lo_s8, ym_hi_s8, yp_lo_s8, yp_hi_s8;
	logic signed [YW-1:0] kl_s8, bl_s8, gl_s8;
	logic [64:0]          len_s8;
	logic                 early_s8, inside_s8, go_s8, v_s8;
	logic signed [YW-1:0] a_ext, mf_ext, inc_ext;

	assign a_ext   = YW'(sqrt_a_s[NB]);
	assign mf_ext  = $signed({{(YW - NB){1'b0}}, sqrt_root_s[NB]});
	assign inc_ext = $signed({{(YW - 1){1'b0}}, |sqrt_rem_s[NB]});

	always_ff @(posedge clk) begin
		if (adv) begin
			ym_lo_s8  <= a_ext - mf_ext - inc_ext;
			ym_hi_s8  <= a_ext - mf_ext;
			yp_lo_s8  <= a_ext + mf_ext;
			yp_hi_s8  <= a_ext + mf_ext + inc_ext;
			kl_s8     <= -$signed(YW'(sqrt_el_s[NB]) << (W - COORD_FRAC_BITS));
			bl_s8     <= $signed((YW'(sqrt_len_s[NB]) << W)
				+ (YW'(sqrt_el_s[NB]) << (W - COORD_FRAC_BITS)));
			gl_s8     <= $signed(YW'(sqrt_len_s[NB]) << W);
			len_s8    <= sqrt_len_s[NB];
			early_s8  <= sqrt_early_s[NB];
			inside_s8 <= sqrt_inside_s[NB];
			go_s8     <= sqrt_go_s[NB];
		end
	end

	// ---------------- s9 and divider stages ----------------
	logic [DW-1:0] div_rem_s    [0:T];
	logic [T-1:0]  div_q_s      [0:T];
	logic [64:0]   div_len_s    [0:T];
	logic          div_hitr_s   [0:T];
	logic          div_neg_s    [0:T];
	logic          div_full_s   [0:T];
	logic          div_early_s  [0:T];
	logic          div_inside_s [0:T];
	logic [T:0]    div_v_s;
	logic          m_ok, p_ok;

	assign m_ok = (kl_s8 <= ym_lo_s8) && (ym_hi_s8 <= bl_s8);
	assign p_ok = (kl_s8 <= yp_lo_s8) && (yp_hi_s8 <= bl_s8);

	always_ff @(posedge clk) begin
		if (adv) begin
			// earlier root wins when it lies in range
			div_rem_s[0]    <= m_ok ? ym_lo_s8[DW-1:0] : yp_lo_s8[DW-1:0];
			div_neg_s[0]    <= m_ok ? ym_lo_s8[YW-1] : yp_lo_s8[YW-1];
			div_full_s[0]   <= m_ok ? (ym_lo_s8 >= gl_s8) : (yp_lo_s8 >= gl_s8);
			div_hitr_s[0]   <= go_s8 && (m_ok || p_ok);
			div_q_s[0]      <= '0;
			div_len_s[0]    <= len_s8;
			div_early_s[0]  <= early_s8;
			div_inside_s[0] <= inside_s8;
		end
	end

	for (genvar j = 0; j < T; j++) begin : g_div
		localparam int B = W - 1 - j;
		logic [DW-1:0] dsub;
		logic          take;

		assign dsub = DW'(div_len_s[j]) << B;
		assign take = div_rem_s[j] >= dsub;

		always_ff @(posedge clk) begin
			if (adv) begin
				div_rem_s[j+1]    <= take ? div_rem_s[j] - dsub : div_rem_s[j];
				div_q_s[j+1]      <= div_q_s[j] | (take ? (T'(1) << (T - 1 - j)) : '0);
				div_len_s[j+1]    <= div_len_s[j];
				div_hitr_s[j+1]   <= div_hitr_s[j];
				div_neg_s[j+1]    <= div_neg_s[j];
				div_full_s[j+1]   <= div_full_s[j];
				div_early_s[j+1]  <= div_early_s[j];
				div_inside_s[j+1] <= div_inside_s[j];
			end
		end
	end

	// ---------------- output register ----------------
	logic          out_valid_q, hit_q;
	logic [TW-1:0] hit_time_q;
	logic [TW-1:0] tcode;

	assign tcode = div_full_s[T] ? (TW'(1) << T)
		: (div_neg_s[T] ? '0 : {1'b0, div_q_s[T]});

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_q      <= div_early_s[T] ? div_inside_s[T] : div_hitr_s[T];
			hit_time_q <= (!div_early_s[T] && div_hitr_s[T]) ? tcode : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			sqrt_v_s    <= '0;
			v_s8        <= 1'b0;
			div_v_s     <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			sqrt_v_s    <= {sqrt_v_s[NB-1:0], v_s6};
			v_s8        <= sqrt_v_s[NB];
			div_v_s     <= {div_v_s[T-1:0], v_s8};
			out_valid_q <= div_v_s[T];
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign hit_time  = hit_time_q;

endmodule

/* sv/scfh_check.sv */
module scfh_check import scfh_pkg::*; #(
	parameter int TIME_FRAC_BITS = TIME_FRAC_DEFAULT
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic                    hit,
	input logic [TIME_FRAC_BITS:0] hit_time
);

	// a result held back must stay put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit) && $stable(hit_time))
		else $error("result changed while stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> hit_time == '0)
		else $error("miss with nonzero hit_time");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hit_time <= ((TIME_FRAC_BITS + 1)'(1) << TIME_FRAC_BITS))
		else $error("hit_time above 1.0");

	// an empty result slot never blocks the input side
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

endmodule

bind segment_circle_first_hit scfh_check #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_scfh_check (.*);
